// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on the rising edge, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/szva_pkg.sv -----
// ----------------------------------------------------------------------------
// szva_pkg
// constants shared by the scan zone vote alert block
// ----------------------------------------------------------------------------
package szva_pkg;

	localparam int SZVA_COUNT_WIDTH = 16;
	localparam int NUM_ZONES        = 6;

	// round(tan(20 deg) * 2^16)
	localparam logic signed [15:0] TAN20_Q16 = 16'sd23853;

	// register indexes
	localparam logic [3:0] REG_VOTE_THRESHOLD = 4'd0;
	localparam logic [3:0] REG_DANGER_RADIUS  = 4'd1;
	localparam logic [3:0] REG_WARNING_RADIUS = 4'd2;
	localparam logic [3:0] REG_BOX_X_MIN      = 4'd3;
	localparam logic [3:0] REG_BOX_Y_HALF     = 4'd4;
	localparam logic [3:0] REG_MOUNT_REVERSED = 4'd5;
	localparam logic [3:0] REG_MOUNT_OFFSET_X = 4'd6;
	localparam logic [3:0] REG_MOUNT_OFFSET_Y = 4'd7;

	// register reset values
	localparam logic [15:0]        RST_VOTE_THRESHOLD = 16'd30;
	localparam logic [14:0]        RST_DANGER_RADIUS  = 15'd1000;
	localparam logic [14:0]        RST_WARNING_RADIUS = 15'd1500;
	localparam logic signed [15:0] RST_BOX_X_MIN      = -16'sd1500;
	localparam logic [14:0]        RST_BOX_Y_HALF     = 15'd800;
	localparam logic               RST_MOUNT_REVERSED = 1'b1;

	// zone order: near front/left/right, warning front/left/right
	localparam int ZONE_NEAR_FRONT = 0;
	localparam int ZONE_NEAR_LEFT  = 1;
	localparam int ZONE_NEAR_RIGHT = 2;
	localparam int ZONE_WARN_FRONT = 3;
	localparam int ZONE_WARN_LEFT  = 4;
	localparam int ZONE_WARN_RIGHT = 5;

	// vibration levels
	localparam logic [2:0] LVL_OFF  = 3'd0;
	localparam logic [2:0] LVL_LOW  = 3'd1;
	localparam logic [2:0] LVL_MID  = 3'd3;
	localparam logic [2:0] LVL_HIGH = 3'd5;

	typedef logic [NUM_ZONES-1:0] zone_vec_t;

endpackage

// ----- hw/rtl/scan_zone_vote_alert.sv -----
// ----------------------------------------------------------------------------
// scan_zone_vote_alert
// Takes one scanner point per cycle unless a result is stalled and keeps
// six zone counters (near and warning ring, each split front/left/right).
// On the point flagged last_of_scan the counters are voted against
// vote_threshold, one set of left/right vibration settings is produced and
// the counters are cleared. Throughput is one point per clock while no
// result is stalled; a result passes the input register, transform,
// multipliers, zone compare and the counter/vote stage into the output
// register. While a result waits on out_ready the whole pipeline holds and
// in_ready is low. A register write applies to every point transferred at
// the same edge or later; the radius squares are registered in the cycle
// after a write, which is still ahead of the ring compare of such a point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scan_zone_vote_alert import szva_pkg::*; #(
	parameter int COUNT_WIDTH = SZVA_COUNT_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_write,
	input  logic [3:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] point_x_mm,
	input  logic signed [15:0] point_y_mm,
	input  logic               point_valid,
	input  logic               last_of_scan,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         left_frequency,
	output logic [2:0]         left_intensity,
	output logic [2:0]         right_frequency,
	output logic [2:0]         right_intensity
);

	localparam int CmpWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

	// configuration registers
	logic [15:0]        vote_threshold_q;
	logic [14:0]        danger_radius_q;
	logic [14:0]        warning_radius_q;
	logic signed [15:0] box_x_min_q;
	logic [14:0]        box_y_half_q;
	logic               mount_reversed_q;
	logic signed [15:0] mount_offset_x_q;
	logic signed [15:0] mount_offset_y_q;
	logic [29:0]        danger_sq_q;
	logic [29:0]        warning_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vote_threshold_q <= RST_VOTE_THRESHOLD;
			danger_radius_q  <= RST_DANGER_RADIUS;
			warning_radius_q <= RST_WARNING_RADIUS;
			box_x_min_q      <= RST_BOX_X_MIN;
			box_y_half_q     <= RST_BOX_Y_HALF;
			mount_reversed_q <= RST_MOUNT_REVERSED;
			mount_offset_x_q <= '0;
			mount_offset_y_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_VOTE_THRESHOLD: vote_threshold_q <= cfg_data;
				REG_DANGER_RADIUS:  danger_radius_q  <= cfg_data[14:0];
				REG_WARNING_RADIUS: warning_radius_q <= cfg_data[14:0];
				REG_BOX_X_MIN:      box_x_min_q      <= $signed(cfg_data);
				REG_BOX_Y_HALF:     box_y_half_q     <= cfg_data[14:0];
				REG_MOUNT_REVERSED: mount_reversed_q <= cfg_data[0];
				REG_MOUNT_OFFSET_X: mount_offset_x_q <= $signed(cfg_data);
				REG_MOUNT_OFFSET_Y: mount_offset_y_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			danger_sq_q  <= 30'(RST_DANGER_RADIUS) * 30'(RST_DANGER_RADIUS);
			warning_sq_q <= 30'(RST_WARNING_RADIUS) * 30'(RST_WARNING_RADIUS);
		end else begin
			danger_sq_q  <= 30'(danger_radius_q) * 30'(danger_radius_q);
			warning_sq_q <= 30'(warning_radius_q) * 30'(warning_radius_q);
		end
	end

	// pipeline control: the pipeline and zone counters hold while a result waits
	logic adv;
	assign adv      = !(out_valid && !out_ready);
	assign in_ready = adv;

	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: input register
	logic signed [15:0] px_s1, py_s1;
	logic               pval_s1, last_s1;

	// stage 2: robot-frame point
	logic signed [17:0] rx_s2, ry_s2;
	logic               keep_s2, last_s2;

	// stage 3: products
	logic signed [17:0] rx_s3, ry_s3;
	logic [35:0]        d2_s3;
	logic signed [35:0] lim_s3;
	logic               keep_s3, last_s3;

	// stage 4: zone hit
	zone_vec_t          zone_s4;
	logic               last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// keep box test and frame change
	logic signed [16:0] py_ext, yh_ext;
	logic               keep_a;
	logic signed [17:0] fx_a, fy_a, rx_a, ry_a;

	always_comb begin
		py_ext = {py_s1[15], py_s1};
		yh_ext = $signed({2'b00, box_y_half_q});
		keep_a = pval_s1 && (px_s1 > box_x_min_q) && (px_s1 < 16'sd0)
			&& (py_ext > -yh_ext) && (py_ext < yh_ext);
		fx_a   = {{2{px_s1[15]}}, px_s1};
		fy_a   = {{2{py_s1[15]}}, py_s1};
		if (mount_reversed_q) begin
			fx_a = -fx_a;
			fy_a = -fy_a;
		end
		rx_a = fx_a + {{2{mount_offset_x_q[15]}}, mount_offset_x_q};
		ry_a = fy_a + {{2{mount_offset_y_q[15]}}, mount_offset_y_q};
	end

	// squares and tangent product
	logic signed [35:0] xx_b, yy_b, lim_b;

	always_comb begin
		xx_b  = 36'(rx_s2) * 36'(rx_s2);
		yy_b  = 36'(ry_s2) * 36'(ry_s2);
		lim_b = 36'(rx_s2) * 36'(TAN20_Q16);
	end

	// ring and sector compares
	logic signed [17:0] nry_c, nrx_c;
	logic signed [35:0] yl_c, nyl_c, ayl_c;
	logic               near_c, warn_c, front_c, left_c, right_c;
	zone_vec_t          zone_c;

	always_comb begin
		nry_c   = -ry_s3;
		nrx_c   = -rx_s3;
		yl_c    = $signed({{2{ry_s3[17]}}, ry_s3, 16'h0000});
		nyl_c   = $signed({{2{nry_c[17]}}, nry_c, 16'h0000});
		ayl_c   = ry_s3[17] ? nyl_c : yl_c;
		near_c  = d2_s3 < {6'b0, danger_sq_q};
		warn_c  = !near_c && (d2_s3 < {6'b0, warning_sq_q});
		front_c = ayl_c <= lim_s3;
		left_c  = (yl_c > lim_s3) && (ry_s3 < rx_s3);
		right_c = (nyl_c > lim_s3) && (ry_s3 > nrx_c);
		zone_c  = '0;
		if (keep_s3) begin
			zone_c[ZONE_NEAR_FRONT] = near_c && front_c;
			zone_c[ZONE_NEAR_LEFT]  = near_c && left_c;
			zone_c[ZONE_NEAR_RIGHT] = near_c && right_c;
			zone_c[ZONE_WARN_FRONT] = warn_c && front_c;
			zone_c[ZONE_WARN_LEFT]  = warn_c && left_c;
			zone_c[ZONE_WARN_RIGHT] = warn_c && right_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1   <= point_x_mm;
			py_s1   <= point_y_mm;
			pval_s1 <= point_valid;
			last_s1 <= last_of_scan;

			rx_s2   <= rx_a;
			ry_s2   <= ry_a;
			keep_s2 <= keep_a;
			last_s2 <= last_s1;

			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;
			d2_s3   <= $unsigned(xx_b) + $unsigned(yy_b);
			lim_s3  <= lim_b;
			keep_s3 <= keep_s2;
			last_s3 <= last_s2;

			zone_s4 <= zone_c;
			last_s4 <= last_s3;
		end
	end

	// zone counters and vote
	logic [COUNT_WIDTH-1:0] cnt_q [NUM_ZONES];
	logic [COUNT_WIDTH-1:0] cnt_nxt [NUM_ZONES];
	zone_vec_t              fire;
	logic                   scan_end;
	logic [2:0]             lf, li, rf, ri;
	logic                   all_clear;

	assign scan_end = adv && v_s4 && last_s4;

	always_comb begin
		all_clear = 1'b1;
		for (int i = 0; i < NUM_ZONES; i++) begin
			cnt_nxt[i] = cnt_q[i];
			if (v_s4 && zone_s4[i] && (cnt_q[i] != CountMax)) begin
				cnt_nxt[i] = cnt_q[i] + COUNT_WIDTH'(1);
			end
			fire[i] = CmpWidth'(cnt_nxt[i]) > CmpWidth'(vote_threshold_q);
			if (cnt_q[i] != '0) begin
				all_clear = 1'b0;
			end
		end
	end

	always_comb begin
		lf = LVL_OFF;
		li = LVL_OFF;
		rf = LVL_OFF;
		ri = LVL_OFF;
		if (fire[ZONE_NEAR_FRONT]) begin
			lf = LVL_MID;
			li = LVL_HIGH;
			rf = LVL_MID;
			ri = LVL_HIGH;
		end
		if (fire[ZONE_NEAR_LEFT]) begin
			lf = LVL_HIGH;
			li = LVL_HIGH;
		end
		if (fire[ZONE_NEAR_RIGHT]) begin
			rf = LVL_HIGH;
			ri = LVL_HIGH;
		end
		// warning front only when a side is still quiet
		if (fire[ZONE_WARN_FRONT] && !(lf != LVL_OFF && rf != LVL_OFF)) begin
			lf = LVL_LOW;
			li = LVL_MID;
			rf = LVL_LOW;
			ri = LVL_MID;
		end
		if (fire[ZONE_WARN_LEFT] && lf == LVL_OFF) begin
			lf = LVL_MID;
			li = LVL_MID;
		end
		if (fire[ZONE_WARN_RIGHT] && rf == LVL_OFF) begin
			rf = LVL_MID;
			ri = LVL_MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ZONES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (adv && v_s4) begin
			for (int i = 0; i < NUM_ZONES; i++) begin
				cnt_q[i] <= last_s4 ? '0 : cnt_nxt[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (scan_end) begin
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_end) begin
			left_frequency  <= lf;
			left_intensity  <= li;
			right_frequency <= rf;
			right_intensity <= ri;
		end
	end

	`ASSERT_SAME(a_stall_blocks_input, clk, arst_n, out_valid && !out_ready, !in_ready,
		"input accepted while a result is stalled")
	`ASSERT_SAME(a_one_zone, clk, arst_n, v_s4, $onehot0(zone_s4),
		"point classified into more than one zone")
	`ASSERT_NEXT(a_scan_clears, clk, arst_n, scan_end, all_clear,
		"zone counters not cleared after scan end")
	`ASSERT_SAME(a_result_from_last, clk, arst_n, $rose(out_valid),
		$past(v_s4) && $past(last_s4), "result without a last point")

endmodule
